[design/ordered_list_engine_macros.svh]
// assertion macros shared by the ordered list engine modules
// no dependencies; included by files that carry assertions
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define OLE_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("ole assertion failed");

// next-cycle implication, disabled in reset
`define OLE_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("ole assertion failed");

`endif

[design/ole_pkg.sv]
// shared types and constants of the ordered list engine
// no dependencies
package ole_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int VAL_W    = 32;

  localparam logic [2:0] ACT_INSERT_FRONT = 3'd0;
  localparam logic [2:0] ACT_REMOVE_FRONT = 3'd1;
  localparam logic [2:0] ACT_REMOVE_BACK  = 3'd2;
  localparam logic [2:0] ACT_REMOVE_VALUE = 3'd3;
  localparam logic [2:0] ACT_CLEAR        = 3'd4;

  localparam logic [2:0] OP_INS = 3'd0;
  localparam logic [2:0] OP_RMF = 3'd1;
  localparam logic [2:0] OP_RMB = 3'd2;
  localparam logic [2:0] OP_RMV = 3'd3;
  localparam logic [2:0] OP_CLR = 3'd4;
  localparam logic [2:0] OP_NOP = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef struct packed {
    logic [2:0]              op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

[design/ole_if.sv]
// handshake channels of the ordered list engine
// depends on ole_pkg
interface ole_req_if (input logic clk);
  logic                             valid;
  logic                             ready;
  logic [2:0]                       action;
  logic signed [ole_pkg::VAL_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

interface ole_rsp_if (input logic clk);
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic signed [ole_pkg::VAL_W-1:0] removed_value;
  logic [ole_pkg::CNT_W-1:0]        removed_count;
  logic [ole_pkg::CNT_W-1:0]        length;

  modport source (output valid, status, removed_value, removed_count, length, input ready);
  modport sink (input valid, status, removed_value, removed_count, length, output ready);
endinterface

[design/ole_ram.sv]
// generic simple dual port ram, registered read
// no dependencies
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/ole_front.sv]
// front end: accepts requests, decodes the action, two-entry command queue
// depends on ole_pkg, ole_if, ordered_list_engine_macros.svh
`include "ordered_list_engine_macros.svh"

module ole_front (
  input  logic             clk,
  input  logic             rst,
  ole_req_if.sink          req,
  output logic             cmd_valid,
  output ole_pkg::cmd_t    cmd,
  input  logic             cmd_pop
);
  ole_pkg::cmd_t slots [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    fill;
  logic          push;
  ole_pkg::cmd_t decoded;

  always_comb begin
    decoded.value = req.value;
    unique case (req.action)
      ole_pkg::ACT_INSERT_FRONT: decoded.op = ole_pkg::OP_INS;
      ole_pkg::ACT_REMOVE_FRONT: decoded.op = ole_pkg::OP_RMF;
      ole_pkg::ACT_REMOVE_BACK:  decoded.op = ole_pkg::OP_RMB;
      ole_pkg::ACT_REMOVE_VALUE: decoded.op = ole_pkg::OP_RMV;
      ole_pkg::ACT_CLEAR:        decoded.op = ole_pkg::OP_CLR;
      default:                   decoded.op = ole_pkg::OP_NOP;
    endcase
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= decoded;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (cmd_pop) rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(cmd_pop);
    end
  end

  `OLE_ASSERT_NOW(a_pop_nonempty, clk, rst, cmd_pop, fill != 2'd0)
  `OLE_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= 2'd2)
  `OLE_ASSERT_NEXT(a_push_fills, clk, rst, push && !cmd_pop, fill != 2'd0)
endmodule

[design/ole_back.sv]
// back end: executes list commands on a circular buffer in ram
// depends on ole_pkg, ole_if, ole_ram, ordered_list_engine_macros.svh
`include "ordered_list_engine_macros.svh"

module ole_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  ole_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  ole_rsp_if.source        rsp
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;

  logic [2:0]                       state;
  logic [ole_pkg::ADDR_W-1:0]       head;
  logic [ole_pkg::CNT_W-1:0]        count;
  logic [ole_pkg::CNT_W-1:0]        pos;
  logic [2:0]                       op;
  logic signed [ole_pkg::VAL_W-1:0] key;
  logic signed [ole_pkg::VAL_W-1:0] hit_value;

  logic                       we;
  logic [ole_pkg::ADDR_W-1:0] waddr;
  logic [ole_pkg::ADDR_W-1:0] raddr;
  logic [ole_pkg::VAL_W-1:0]  rdata;
  logic [ole_pkg::CNT_W-1:0]  pos_inc;
  logic [ole_pkg::CNT_W-1:0]  pos_inc2;
  logic                       start;
  // insert writes the key, so the ram write data is muxed below
  logic [ole_pkg::VAL_W-1:0]  wdata_mux;

  assign start    = (state == S_IDLE) && cmd_valid && !rsp.valid;
  assign cmd_pop  = start;
  assign pos_inc  = pos + 1'b1;
  assign pos_inc2 = pos + 2'd2;

  ole_ram #(.WIDTH(ole_pkg::VAL_W), .DEPTH(ole_pkg::CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata_mux),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    we        = 1'b0;
    waddr     = head - 1'b1;
    wdata_mux = cmd.value;
    raddr     = head;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd.op == ole_pkg::OP_INS && count != ole_pkg::CAP_CNT) we = 1'b1;
          if (cmd.op == ole_pkg::OP_RMB) raddr = head + ole_pkg::ADDR_W'(count - 1'b1);
        end
      end
      S_SEARCH: raddr = head + ole_pkg::ADDR_W'(pos_inc);
      S_SHIFT: begin
        we        = 1'b1;
        waddr     = head + ole_pkg::ADDR_W'(pos);
        wdata_mux = rdata;
        raddr     = head + ole_pkg::ADDR_W'(pos_inc2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op                <= cmd.op;
            key               <= cmd.value;
            pos               <= '0;
            rsp.status        <= ole_pkg::ST_OK;
            rsp.removed_value <= '0;
            rsp.removed_count <= '0;
            rsp.length        <= count;
            case (cmd.op)
              ole_pkg::OP_INS: begin
                rsp.valid <= 1'b1;
                if (count == ole_pkg::CAP_CNT) begin
                  rsp.status <= ole_pkg::ST_FULL;
                end else begin
                  head       <= head - 1'b1;
                  count      <= count + 1'b1;
                  rsp.length <= count + 1'b1;
                end
              end
              ole_pkg::OP_RMF, ole_pkg::OP_RMB: begin
                if (count == '0) begin
                  rsp.valid  <= 1'b1;
                  rsp.status <= ole_pkg::ST_EMPTY;
                end else begin
                  state <= S_READ;
                end
              end
              ole_pkg::OP_RMV: begin
                if (count == '0) begin
                  rsp.valid  <= 1'b1;
                  rsp.status <= ole_pkg::ST_NOT_FOUND;
                end else begin
                  state <= S_SEARCH;
                end
              end
              ole_pkg::OP_CLR: begin
                rsp.valid         <= 1'b1;
                rsp.removed_count <= count;
                rsp.length        <= '0;
                count             <= '0;
              end
              default: rsp.valid <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          rsp.valid         <= 1'b1;
          rsp.removed_value <= rdata;
          rsp.removed_count <= ole_pkg::CNT_W'(1);
          rsp.length        <= count - 1'b1;
          count             <= count - 1'b1;
          if (op == ole_pkg::OP_RMF) head <= head + 1'b1;
          state <= S_IDLE;
        end
        S_SEARCH: begin
          if (rdata == key) begin
            hit_value <= rdata;
            if (pos_inc < count) begin
              state <= S_SHIFT;
            end else begin
              rsp.valid         <= 1'b1;
              rsp.removed_value <= rdata;
              rsp.removed_count <= ole_pkg::CNT_W'(1);
              rsp.length        <= count - 1'b1;
              count             <= count - 1'b1;
              state             <= S_IDLE;
            end
          end else if (pos_inc < count) begin
            pos <= pos_inc;
          end else begin
            rsp.valid  <= 1'b1;
            rsp.status <= ole_pkg::ST_NOT_FOUND;
            state      <= S_IDLE;
          end
        end
        S_SHIFT: begin
          // entry at pos+1 moves into pos
          if (pos_inc2 < count) begin
            pos <= pos_inc;
          end else begin
            rsp.valid         <= 1'b1;
            rsp.removed_value <= hit_value;
            rsp.removed_count <= ole_pkg::CNT_W'(1);
            rsp.length        <= count - 1'b1;
            count             <= count - 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OLE_ASSERT_NOW(a_busy_no_result, clk, rst, state != S_IDLE, !rsp.valid)
  `OLE_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= ole_pkg::CAP_CNT)
  `OLE_ASSERT_NOW(a_full_length, clk, rst, rsp.valid && rsp.status == ole_pkg::ST_FULL,
                  rsp.length == ole_pkg::CAP_CNT)
endmodule

[design/ordered_list_engine.sv]
// ordered list engine top level: front end, command queue, back end
// depends on ole_pkg, ole_if, ole_front, ole_back
//
// Bounded ordered list of up to 64 signed 32-bit values held in one ram as a
// circular buffer. Each request yields exactly one response. Insert, clear and
// unused actions complete from the back end's idle state, remove front and
// remove back pass through a read state, and remove by value searches entry by
// entry up to the hit, then makes one move per later entry; the single read and
// single write port of the entry ram is why it works one entry at a time. The
// back end starts a command only once the previous response has left its output
// register; a two-entry queue in the front end keeps taking requests while it
// has room.
module ordered_list_engine (
  input logic clk,
  input logic rst,
  ole_req_if.sink   req,
  ole_rsp_if.source rsp
);
  logic          cmd_valid;
  logic          cmd_pop;
  ole_pkg::cmd_t cmd;

  ole_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ole_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );
endmodule

[bench/ordered_list_engine_test.sv]
// self-checking testbench for the ordered list engine
// depends on ole_pkg, ole_if and the ordered_list_engine rtl
`timescale 1ns / 1ps

module ordered_list_engine_test;

  localparam int UNUSED_ACTION = 5;

  typedef struct packed {
    logic [1:0]                       status;
    logic signed [ole_pkg::VAL_W-1:0] removed_value;
    logic [ole_pkg::CNT_W-1:0]        removed_count;
    logic [ole_pkg::CNT_W-1:0]        length;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ole_req_if req (.clk(clk));
  ole_rsp_if rsp (.clk(clk));

  ordered_list_engine i_dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the list, position 0 is the front
  logic signed [ole_pkg::VAL_W-1:0] shadow_list[$];
  outcome_t pending_outcomes[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  function automatic outcome_t apply_action(logic [2:0] action,
                                            logic signed [ole_pkg::VAL_W-1:0] value);
    outcome_t o;
    int hit;
    o = '0;
    hit = -1;
    case (action)
      ole_pkg::ACT_INSERT_FRONT: begin
        if (shadow_list.size() >= ole_pkg::CAPACITY) o.status = ole_pkg::ST_FULL;
        else shadow_list.push_front(value);
      end
      ole_pkg::ACT_REMOVE_FRONT, ole_pkg::ACT_REMOVE_BACK: begin
        if (shadow_list.size() == 0) o.status = ole_pkg::ST_EMPTY;
        else begin
          o.removed_value = (action == ole_pkg::ACT_REMOVE_FRONT) ? shadow_list.pop_front()
                                                                  : shadow_list.pop_back();
          o.removed_count = ole_pkg::CNT_W'(1);
        end
      end
      ole_pkg::ACT_REMOVE_VALUE: begin
        for (int i = 0; i < shadow_list.size(); i++)
          if (hit < 0 && shadow_list[i] == value) hit = i;
        if (hit < 0) o.status = ole_pkg::ST_NOT_FOUND;
        else begin
          o.removed_value = shadow_list[hit];
          o.removed_count = ole_pkg::CNT_W'(1);
          shadow_list.delete(hit);
        end
      end
      ole_pkg::ACT_CLEAR: begin
        o.removed_count = ole_pkg::CNT_W'(shadow_list.size());
        shadow_list.delete();
      end
      default: ;
    endcase
    o.length = ole_pkg::CNT_W'(shadow_list.size());
    return o;
  endfunction

  initial begin
    req.valid = 1'b0;
    req.action = '0;
    req.value = '0;
    rsp.ready = 1'b0;
  end

  // valid stays high between back-to-back transfers; it drops only while idling and after the last request
  task automatic send_action(logic [2:0] action, logic signed [ole_pkg::VAL_W-1:0] value);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.action <= action;
    req.value <= value;
    do @(posedge clk); while (!req.ready);
    pending_outcomes.push_back(apply_action(action, value));
    @(negedge clk);
  endtask

  // receiver ready, with random idling and one long hold-off in the backpressure test
  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else rsp.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: status %0d length %0d",
                                       rsp.status, rsp.length);
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp.status !== want.status || rsp.removed_value !== want.removed_value ||
            rsp.removed_count !== want.removed_count || rsp.length !== want.length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d val %0d cnt %0d len %0d, got st %0d val %0d cnt %0d len %0d",
                     want.status, want.removed_value, want.removed_count, want.length,
                     rsp.status, rsp.removed_value, rsp.removed_count, rsp.length);
        end
      end
    end
  end

  function automatic logic signed [ole_pkg::VAL_W-1:0] pick_value();
    int k;
    k = $urandom_range(9, 0);
    if (k == 0) return 32'sh8000_0000;
    if (k == 1) return 32'sh7fff_ffff;
    if (k < 5) return $urandom();
    // narrow range so searches hit and duplicates occur
    return $signed(32'($urandom_range(15, 0))) - 8;
  endfunction

  function automatic logic signed [ole_pkg::VAL_W-1:0] existing_or_random();
    if (shadow_list.size() > 0 && $urandom_range(3, 0) != 0)
      return shadow_list[$urandom_range(shadow_list.size() - 1, 0)];
    return pick_value();
  endfunction

  task automatic test_directed();
    send_action(ole_pkg::ACT_REMOVE_FRONT, 0);
    send_action(ole_pkg::ACT_REMOVE_BACK, 0);
    send_action(ole_pkg::ACT_REMOVE_VALUE, 0);
    send_action(ole_pkg::ACT_CLEAR, 0);
    send_action(ole_pkg::ACT_INSERT_FRONT, 32'sh8000_0000);
    send_action(ole_pkg::ACT_INSERT_FRONT, 32'sh7fff_ffff);
    send_action(ole_pkg::ACT_INSERT_FRONT, -1);
    send_action(ole_pkg::ACT_INSERT_FRONT, 32'sh7fff_ffff);
    send_action(ole_pkg::ACT_REMOVE_VALUE, 32'sh7fff_ffff);
    send_action(ole_pkg::ACT_REMOVE_VALUE, 5);
    send_action(ole_pkg::ACT_REMOVE_BACK, 0);
    send_action(ole_pkg::ACT_REMOVE_FRONT, 0);
    send_action(3'(UNUSED_ACTION), 1);
    send_action(3'd6, 2);
    send_action(3'd7, -1);
    send_action(ole_pkg::ACT_CLEAR, 0);
    send_action(ole_pkg::ACT_REMOVE_VALUE, 32'sh8000_0000);
  endtask

  // fill to capacity, overflow, and search at the deep end
  task automatic test_full_list();
    for (int i = 0; i < ole_pkg::CAPACITY; i++) send_action(ole_pkg::ACT_INSERT_FRONT, i);
    send_action(ole_pkg::ACT_INSERT_FRONT, 99);
    send_action(ole_pkg::ACT_REMOVE_VALUE, 0);
    send_action(ole_pkg::ACT_INSERT_FRONT, 32'sh8000_0000);
    send_action(ole_pkg::ACT_INSERT_FRONT, 1);
    send_action(ole_pkg::ACT_CLEAR, 0);
  endtask

  task automatic test_random(int count);
    int k;
    logic [2:0] action;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99, 0);
      // weighted toward inserts, with the same mix throughout the test
      if (k < 45) action = ole_pkg::ACT_INSERT_FRONT;
      else if (k < 58) action = ole_pkg::ACT_REMOVE_FRONT;
      else if (k < 70) action = ole_pkg::ACT_REMOVE_BACK;
      else if (k < 95) action = ole_pkg::ACT_REMOVE_VALUE;
      else if (k < 98) action = ole_pkg::ACT_CLEAR;
      else action = 3'($urandom_range(7, UNUSED_ACTION));
      send_action(action, action == ole_pkg::ACT_REMOVE_VALUE ? existing_or_random()
                                                              : pick_value());
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send_action(ole_pkg::ACT_INSERT_FRONT, pick_value());
    send_action(ole_pkg::ACT_REMOVE_VALUE, existing_or_random());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 66;
    test_directed();
    test_full_list();
    test_random(260);
    send_idle_pct = 66;
    recv_idle_pct = 24;
    test_backpressure();
    test_random(260);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(260);
    req.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
